/* rtl/pstk_pkg.sv */
// Shared constants, codes and types of the sorted priority stack.
`default_nettype none
package pstk_pkg;

  localparam int unsigned CAPACITY   = 16;
  localparam int unsigned ELEM_WIDTH = 32;
  localparam int unsigned PRIO_WIDTH = 8;
  localparam int unsigned CNT_WIDTH  = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_POP_EMPTY = 2'd1,
    ST_PUSH_FULL = 2'd2
  } status_e;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_e;

  // One stored entry.
  typedef struct packed {
    logic [ELEM_WIDTH-1:0] elem;
    logic [PRIO_WIDTH-1:0] prio;
  } entry_t;

  // Operation broadcast to every cell of the chain.
  typedef struct packed {
    logic   push;
    logic   pop;
    entry_t entry;
  } cmd_t;

endpackage
`default_nettype wire

/* rtl/pstk_cell.sv */
// One cell of the sorted chain: holds an entry and shifts it with its neighbors.
`default_nettype none
module pstk_cell (
  input  wire logic            clk_i,
  input  wire pstk_pkg::cmd_t   cmd_i,
  input  wire logic            occ_i,
  input  wire logic            left_ge_i,
  input  wire pstk_pkg::entry_t left_i,
  input  wire pstk_pkg::entry_t right_i,
  output logic                 ge_o,
  output pstk_pkg::entry_t      entry_o
);
  import pstk_pkg::*;

  entry_t entry_q, entry_d;

  // The cell stays ahead of a new entry only while it holds a strictly higher
  // priority; since the chain is sorted these flags form a prefix.
  assign ge_o = occ_i && (entry_q.prio > cmd_i.entry.prio);

  always_comb begin
    entry_d = entry_q;
    if (cmd_i.push) begin
      if (!ge_o) begin
        entry_d = left_ge_i ? cmd_i.entry : left_i;
      end
    end else if (cmd_i.pop) begin
      entry_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule
`default_nettype wire

/* rtl/priority_stack_top.sv */
// Top level of the sorted priority stack built as a chain of cells.
`default_nettype none
// Usage:
//   A command word (mode, element, priority) is taken on a rising edge with
//   start_i high and busy_o low. Mode 0 pushes the entry ahead of every entry
//   of equal or lower priority; mode 1 pops the top entry.
//   Every cell of the chain updates in the same cycle, so busy_o stays low and
//   one command is taken every clock cycle.
//   The result word (top element, top priority, count, empty flag, status)
//   appears in the cycle after the command, marked by valid_o for exactly one
//   cycle. The receiver cannot stall; a result must be taken when shown.
//   A push on a full stack or a pop on an empty one is refused with an error
//   status and leaves the contents unchanged.
//   Reset clears the entry count, the result strobe and the status; the cells keep
//   whatever they held and are never read before being written.
module priority_stack_top (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start_i,
  output logic                                 busy_o,
  input  wire logic                            mode_i,
  input  wire logic [pstk_pkg::ELEM_WIDTH-1:0] elem_in_i,
  input  wire logic [pstk_pkg::PRIO_WIDTH-1:0] prio_in_i,
  output logic                                 valid_o,
  output logic [pstk_pkg::ELEM_WIDTH-1:0]      top_elem_o,
  output logic [pstk_pkg::PRIO_WIDTH-1:0]      top_prio_o,
  output logic [pstk_pkg::CNT_WIDTH-1:0]       entry_count_o,
  output logic                                 is_empty_o,
  output logic [1:0]                           status_o
);
  import pstk_pkg::*;

  logic                 accept;
  logic                 full, empty;
  cmd_t                 cmd;
  status_e              status_d, status_q;
  logic [CNT_WIDTH-1:0] count_d, count_q;
  logic                 valid_q;

  logic   [CAPACITY-1:0] ge;
  logic   [CAPACITY-1:0] occ;
  entry_t                cells [CAPACITY];

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;
  assign full   = (count_q == CNT_WIDTH'(CAPACITY));
  assign empty  = (count_q == '0);

  always_comb begin
    cmd.entry.elem = elem_in_i;
    cmd.entry.prio = prio_in_i;
    cmd.push       = 1'b0;
    cmd.pop        = 1'b0;
    status_d       = ST_OK;
    count_d        = count_q;
    if (accept) begin
      if (op_e'(mode_i) == OP_PUSH) begin
        if (full) begin
          status_d = ST_PUSH_FULL;
        end else begin
          cmd.push = 1'b1;
          count_d  = count_q + 1'b1;
        end
      end else begin
        if (empty) begin
          status_d = ST_POP_EMPTY;
        end else begin
          cmd.pop = 1'b1;
          count_d = count_q - 1'b1;
        end
      end
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t left, right;
    logic   left_ge;

    assign occ[i] = (CNT_WIDTH'(i) < count_q);

    if (i == 0) begin : g_head
      assign left    = cmd.entry;
      assign left_ge = 1'b1;
    end else begin : g_body
      assign left    = cells[i-1];
      assign left_ge = ge[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right = cells[i];
    end else begin : g_mid
      assign right = cells[i+1];
    end

    pstk_cell u_cell (
      .clk_i     (clk_i),
      .cmd_i     (cmd),
      .occ_i     (occ[i]),
      .left_ge_i (left_ge),
      .left_i    (left),
      .right_i   (right),
      .ge_o      (ge[i]),
      .entry_o   (cells[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      valid_q  <= 1'b0;
      status_q <= ST_OK;
    end else begin
      count_q <= count_d;
      valid_q <= accept;
      if (accept) begin
        status_q <= status_d;
      end
    end
  end

  assign valid_o       = valid_q;
  assign top_elem_o    = empty ? '0 : cells[0].elem;
  assign top_prio_o    = empty ? '0 : cells[0].prio;
  assign entry_count_o = count_q;
  assign is_empty_o    = empty;
  assign status_o      = status_q;

`ifndef SYNTHESIS
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_WIDTH'(CAPACITY))
    else $error("entry count exceeds capacity");

  a_strobe_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> valid_q)
    else $error("result strobe missing after an accepted command");

  a_refused_push : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && status_q == ST_PUSH_FULL) |-> full && $stable(count_q))
    else $error("refused push changed the entry count");

  a_refused_pop : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && status_q == ST_POP_EMPTY) |-> empty)
    else $error("refused pop on a non-empty stack");
`endif

endmodule
`default_nettype wire

/* bench/testbench.sv */
// Self-checking testbench for the sorted priority stack: directed and random push/pop words.
module testbench;
  import pstk_pkg::*;

  localparam int unsigned RANDOM_WORDS = 1200;
  localparam int unsigned CALM_TAIL    = 150;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned SETTLE_CYCLES = 4;

  typedef struct packed {
    op_e                   mode;
    logic [ELEM_WIDTH-1:0] elem;
    logic [PRIO_WIDTH-1:0] prio;
    logic [3:0]            gap;
    logic                  drain;
  } cmd_word_t;

  typedef struct packed {
    logic [ELEM_WIDTH-1:0] top_elem;
    logic [PRIO_WIDTH-1:0] top_prio;
    logic [CNT_WIDTH-1:0]  count;
    logic                  empty;
    status_e               status;
  } stack_view_t;

  logic                  clk      = 1'b0;
  logic                  rst_n    = 1'b0;
  logic                  start    = 1'b0;
  logic                  mode_in  = 1'b0;
  logic [ELEM_WIDTH-1:0] elem_in  = '0;
  logic [PRIO_WIDTH-1:0] prio_in  = '0;
  logic                  busy;
  logic                  valid;
  logic [ELEM_WIDTH-1:0] top_elem;
  logic [PRIO_WIDTH-1:0] top_prio;
  logic [CNT_WIDTH-1:0]  entry_count;
  logic                  is_empty;
  logic [1:0]            status;

  // Shadow copy of the stack contents; slot 0 is the top.
  entry_t      shadow_slot [CAPACITY];
  int unsigned shadow_fill = 0;

  cmd_word_t   word_q [$];
  stack_view_t view_q [$];
  cmd_word_t   staged_word;
  cmd_word_t   live_word;
  logic        staged = 1'b0;
  int unsigned gap_left = 0;
  int unsigned mismatches = 0;
  int unsigned words_total = 0;
  int unsigned words_taken = 0;
  int unsigned quiet_cycles = 0;

  priority_stack_top DUT (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .start_i      (start),
    .busy_o       (busy),
    .mode_i       (mode_in),
    .elem_in_i    (elem_in),
    .prio_in_i    (prio_in),
    .valid_o      (valid),
    .top_elem_o   (top_elem),
    .top_prio_o   (top_prio),
    .entry_count_o(entry_count),
    .is_empty_o   (is_empty),
    .status_o     (status)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch on %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $time);
    mismatches++;
  endtask

  // Applies one word to the shadow stack and returns the view it should produce.
  function automatic stack_view_t apply_word(cmd_word_t w);
    stack_view_t v;
    int unsigned pos;
    v.status = ST_OK;
    if (w.mode == OP_PUSH) begin
      if (shadow_fill >= CAPACITY) begin
        v.status = ST_PUSH_FULL;
      end else begin
        pos = 0;
        // A new entry goes ahead of every entry of equal or lower priority.
        while (pos < shadow_fill && shadow_slot[pos].prio > w.prio) pos++;
        for (int unsigned i = shadow_fill; i > pos; i--) shadow_slot[i] = shadow_slot[i - 1];
        shadow_slot[pos] = {w.elem, w.prio};
        shadow_fill++;
      end
    end else if (shadow_fill == 0) begin
      v.status = ST_POP_EMPTY;
    end else begin
      for (int unsigned i = 0; i + 1 < shadow_fill; i++) shadow_slot[i] = shadow_slot[i + 1];
      shadow_fill--;
    end
    v.top_elem = (shadow_fill == 0) ? '0 : shadow_slot[0].elem;
    v.top_prio = (shadow_fill == 0) ? '0 : shadow_slot[0].prio;
    v.count    = CNT_WIDTH'(shadow_fill);
    v.empty    = (shadow_fill == 0);
    return v;
  endfunction

  function automatic cmd_word_t make_word(op_e mode, logic [ELEM_WIDTH-1:0] elem,
                                          logic [PRIO_WIDTH-1:0] prio, int unsigned gap,
                                          logic drain);
    cmd_word_t w;
    w.mode  = mode;
    w.elem  = elem;
    w.prio  = prio;
    w.gap   = 4'(gap);
    w.drain = drain;
    return w;
  endfunction

  always @(posedge clk) begin : drive_words
    logic go;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      go = 1'b0;
      if (start && !busy) begin
        view_q.push_back(apply_word(live_word));
        words_taken++;
      end
      if (start && busy) begin
        go = 1'b1;
      end else begin
        if (!staged && word_q.size() != 0) begin
          staged_word = word_q.pop_front();
          staged = 1'b1;
          gap_left = staged_word.gap;
        end
        if (staged) begin
          if (gap_left != 0) begin
            gap_left--;
          end else if (!(staged_word.drain && view_q.size() != 0)) begin
            go = 1'b1;
            live_word = staged_word;
            staged = 1'b0;
            mode_in <= staged_word.mode;
            elem_in <= staged_word.elem;
            prio_in <= staged_word.prio;
          end
        end
      end
      start <= go;
    end
  end

  always @(posedge clk) begin : check_results
    stack_view_t want;
    if (rst_n && valid) begin
      if (view_q.size() == 0) begin
        report_mismatch("unexpected result word", 64'(status), 64'(0));
      end else begin
        want = view_q.pop_front();
        if (top_elem !== want.top_elem) report_mismatch("top element", top_elem, want.top_elem);
        if (top_prio !== want.top_prio) report_mismatch("top priority", top_prio, want.top_prio);
        if (entry_count !== want.count) report_mismatch("entry count", entry_count, want.count);
        if (is_empty !== want.empty) report_mismatch("empty flag", is_empty, want.empty);
        if (status !== want.status) report_mismatch("status", status, want.status);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if ((start && !busy) || valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("[priority_stack_top] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : run
    int unsigned n;
    int unsigned span;
    int unsigned push_pct;
    int unsigned gap;
    logic        idle_on;
    op_e         mode;
    logic [ELEM_WIDTH-1:0] elem;
    logic [PRIO_WIDTH-1:0] prio;

    // Directed part: refused pop, extremes, ties at both ends, fill to full, refused push.
    word_q.push_back(make_word(OP_POP, '1, '1, 0, 1'b0));
    word_q.push_back(make_word(OP_PUSH, '0, '0, 0, 1'b0));
    word_q.push_back(make_word(OP_PUSH, '1, '1, 0, 1'b0));
    word_q.push_back(make_word(OP_PUSH, 32'h1, '1, 0, 1'b0));
    word_q.push_back(make_word(OP_PUSH, 32'h2, '0, 0, 1'b0));
    word_q.push_back(make_word(OP_POP, '0, '0, 0, 1'b0));
    for (int unsigned i = 0; i < 12; i++) begin
      word_q.push_back(make_word(OP_PUSH, ELEM_WIDTH'(32'h8000_0000 >> i),
                                 PRIO_WIDTH'((i % 4) * 85), 0, 1'b0));
    end
    word_q.push_back(make_word(OP_PUSH, 32'hA5A5_5A5A, '1, 0, 1'b0));
    word_q.push_back(make_word(OP_PUSH, 32'h5A5A_A5A5, '1, 0, 1'b0));
    word_q.push_back(make_word(OP_POP, '0, '0, 0, 1'b0));
    word_q.push_back(make_word(OP_POP, '0, '0, 0, 1'b0));

    // Random part in runs with a push bias, so the stack swings between full and empty.
    n = 0;
    while (n < RANDOM_WORDS) begin
      case ($urandom_range(2, 0))
        0: push_pct = 85;
        1: push_pct = 50;
        default: push_pct = 15;
      endcase
      span = $urandom_range(60, 15);
      idle_on = ($urandom_range(3, 0) != 0);
      for (int unsigned k = 0; k < span && n < RANDOM_WORDS; k++) begin
        mode = ($urandom_range(99, 0) < push_pct) ? OP_PUSH : OP_POP;
        case ($urandom_range(3, 0))
          0: prio = PRIO_WIDTH'($urandom);
          1: prio = PRIO_WIDTH'($urandom_range(3, 0));
          2: prio = $urandom_range(1, 0) ? '1 : '0;
          default: prio = PRIO_WIDTH'($urandom_range(130, 126));
        endcase
        case ($urandom_range(7, 0))
          0: elem = '0;
          1: elem = '1;
          default: elem = ELEM_WIDTH'($urandom);
        endcase
        gap = 0;
        if (idle_on && n < RANDOM_WORDS - CALM_TAIL && $urandom_range(4, 0) == 0) begin
          gap = $urandom_range(10, 1);
        end
        word_q.push_back(make_word(mode, elem, prio, gap,
                                   (n == 0) || (n < RANDOM_WORDS - CALM_TAIL &&
                                                $urandom_range(199, 0) == 0)));
        n++;
      end
    end
    words_total = word_q.size();

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (words_taken != words_total) @(posedge clk);
    while (view_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("[priority_stack_top] OK");
    end else begin
      $display("[priority_stack_top] ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/pstk_pkg.sv
rtl/pstk_cell.sv
rtl/priority_stack_top.sv
bench/testbench.sv
